// ===== rtl/core/sink_cell_screen_unit_macros.svh =====
// Assertion macros shared by the sink cell screen checker.
`ifndef SINK_CELL_SCREEN_UNIT_MACROS_SVH
`define SINK_CELL_SCREEN_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define SCS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sink cell screen: same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define SCS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sink cell screen: next-cycle check failed");

`endif

// ===== rtl/core/scs_pkg.sv =====
// Types, codes and helper functions shared by the sink cell screen modules.
package scs_pkg;

	typedef enum logic [1:0] {
		RSN_PASS  = 2'd0,
		RSN_BELOW = 2'd1,
		RSN_SMALL = 2'd2,
		RSN_JEANS = 2'd3
	} reason_t;

	localparam logic [1:0] MODE_HYDRO = 2'd0;
	localparam logic [1:0] MODE_MHD   = 2'd1;
	localparam logic [1:0] MODE_INT   = 2'd2;

	// Per-item results of the threshold and mass tests.
	typedef struct packed {
		logic        below;
		logic        mass_low;
		logic [31:0] mass;
		logic [31:0] remain;
	} ctx_t;

	typedef struct packed {
		ctx_t               ctx;
		logic [31:0]        rho;
		logic signed [31:0] tot;
		logic signed [31:0] intl;
		logic [46:0]        kin;
		logic [63:0]        sumb;
		logic               movf;
	} front_t;

	typedef struct packed {
		ctx_t               ctx;
		logic [31:0]        rho;
		logic signed [31:0] tot;
		logic signed [31:0] intl;
		logic [46:0]        kin;
		logic               movf;
	} mag_sb_t;

	typedef struct packed {
		ctx_t ctx;
		logic e_neg;
		logic e_zero;
		logic jovf;
	} jsb_t;

	function automatic logic [31:0] sat_max(input int dw);
		if (dw >= 32) begin
			return 32'hFFFF_FFFF;
		end
		return 32'((64'd1 << dw) - 64'd1);
	endfunction

endpackage

// ===== rtl/core/scs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
module scs_div import scs_pkg::*; #(
	parameter int QW   = 32,
	parameter int DW   = 32,
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [DW-1:0]   num_hi,
	input  logic [QW-1:0]   num_lo,
	input  logic [DW-1:0]   den,
	input  logic [SB_W-1:0] sb_in,
	output logic            out_valid,
	output logic [QW-1:0]   quot,
	output logic [SB_W-1:0] sb_out
);

	logic            v_s   [QW];
	logic [DW-1:0]   rem_s [QW];
	logic [QW-1:0]   lo_s  [QW];
	logic [DW-1:0]   den_s [QW];
	logic [SB_W-1:0] sb_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic            p_v;
		logic [DW-1:0]   p_rem;
		logic [QW-1:0]   p_lo;
		logic [DW-1:0]   p_den;
		logic [SB_W-1:0] p_sb;
		logic [DW:0]     trial;
		logic [DW:0]     diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign p_v   = in_valid;
			assign p_rem = num_hi;
			assign p_lo  = num_lo;
			assign p_den = den;
			assign p_sb  = sb_in;
		end else begin : g_next
			assign p_v   = v_s[k-1];
			assign p_rem = rem_s[k-1];
			assign p_lo  = lo_s[k-1];
			assign p_den = den_s[k-1];
			assign p_sb  = sb_s[k-1];
		end

		// The remainder stays below the divisor, so the trial fits one bit more.
		assign trial = {p_rem, p_lo[QW-1]};
		assign diff  = trial - {1'b0, p_den};
		assign ge    = trial >= {1'b0, p_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				lo_s[k]  <= {p_lo[QW-2:0], ge};
				den_s[k] <= p_den;
				sb_s[k]  <= p_sb;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quot      = lo_s[QW-1];
	assign sb_out    = sb_s[QW-1];

endmodule

// ===== rtl/core/scs_sqrt.sv =====
// Pipelined 64-bit integer square root, one root bit per stage, with a sideband word.
module scs_sqrt import scs_pkg::*; #(
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [63:0]     radicand,
	input  logic [SB_W-1:0] sb_in,
	output logic            out_valid,
	output logic [31:0]     root,
	output logic [SB_W-1:0] sb_out
);

	localparam int XW  = 64;
	localparam int NST = XW / 2;

	logic            v_s  [NST];
	logic [XW-1:0]   x_s  [NST];
	logic [XW-1:0]   r_s  [NST];
	logic [SB_W-1:0] sb_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_stage
		localparam logic [XW-1:0] BIT = {{(XW-1){1'b0}}, 1'b1} << (XW - 2 - 2 * k);
		logic            p_v;
		logic [XW-1:0]   p_x;
		logic [XW-1:0]   p_r;
		logic [SB_W-1:0] p_sb;
		logic [XW:0]     sum;
		logic            ge;

		if (k == 0) begin : g_first
			assign p_v  = in_valid;
			assign p_x  = radicand;
			assign p_r  = '0;
			assign p_sb = sb_in;
		end else begin : g_next
			assign p_v  = v_s[k-1];
			assign p_x  = x_s[k-1];
			assign p_r  = r_s[k-1];
			assign p_sb = sb_s[k-1];
		end

		assign sum = {1'b0, p_r} + {1'b0, BIT};
		assign ge  = {1'b0, p_x} >= sum;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= p_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]  <= ge ? (p_x - sum[XW-1:0]) : p_x;
				r_s[k]  <= ge ? ((p_r >> 1) + BIT) : (p_r >> 1);
				sb_s[k] <= p_sb;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign root      = r_s[NST-1][NST-1:0];
	assign sb_out    = sb_s[NST-1];

endmodule

// ===== rtl/core/scs_front.sv =====
// Front stages: threshold test, taken density, sink mass and velocity/field squares.
module scs_front import scs_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [31:0]        cell_density,
	input  logic signed [31:0] tot_energy,
	input  logic signed [31:0] int_energy,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic signed [31:0] mag_x,
	input  logic signed [31:0] mag_y,
	input  logic signed [31:0] mag_z,
	input  logic [31:0]        thr,
	input  logic [16:0]        frac,
	input  logic [31:0]        min_mass,
	input  logic [31:0]        vol,
	output logic               out_valid,
	output front_t             out_data
);

	localparam logic [31:0] SAT = sat_max(DATA_WIDTH);
	localparam logic [16:0] ONE = 17'd65536;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [31:0]        rho_s1, rho_s2, rho_s3;
	logic signed [31:0] tot_s1, tot_s2, tot_s3;
	logic signed [31:0] intl_s1, intl_s2, intl_s3;
	logic               below_s1, below_s2, below_s3;
	logic [48:0]        pprod_s1;
	logic [63:0]        sq_s1 [6];
	logic [31:0]        taken_s2, remain_s2, remain_s3;
	logic [46:0]        kin_s2, kin_s3;
	logic [63:0]        sumb_s2, sumb_s3;
	logic [63:0]        mprod_s3;
	logic               movf_s3;
	front_t             res_s4;

	logic [16:0]        frac_c;
	logic signed [63:0] ext [6];
	logic [31:0]        part, excess, taken;
	logic [63:0]        sumv;
	logic [47:0]        m48;
	logic [31:0]        mass;

	always_comb begin
		frac_c = (frac > ONE) ? ONE : frac;
		ext[0] = 64'(vel_x);
		ext[1] = 64'(vel_y);
		ext[2] = 64'(vel_z);
		ext[3] = 64'(mag_x);
		ext[4] = 64'(mag_y);
		ext[5] = 64'(mag_z);
	end

	// The excess only matters when the cell is above threshold.
	always_comb begin
		part   = pprod_s1[47:16];
		excess = rho_s1 - thr;
		taken  = below_s1 ? 32'd0 : ((excess < part) ? excess : part);
		sumv   = sq_s1[0] + sq_s1[1] + sq_s1[2];
	end

	always_comb begin
		m48  = mprod_s3[63:16];
		mass = below_s3 ? 32'd0 : ((m48 > {16'd0, SAT}) ? SAT : m48[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rho_s1   <= cell_density;
			tot_s1   <= tot_energy;
			intl_s1  <= int_energy;
			below_s1 <= cell_density <= thr;
			pprod_s1 <= 49'(cell_density) * 49'(frac_c);
			for (int i = 0; i < 6; i++) begin
				sq_s1[i] <= unsigned'(ext[i] * ext[i]);
			end

			rho_s2    <= rho_s1;
			tot_s2    <= tot_s1;
			intl_s2   <= intl_s1;
			below_s2  <= below_s1;
			taken_s2  <= taken;
			remain_s2 <= rho_s1 - taken;
			kin_s2    <= sumv[63:17];
			sumb_s2   <= sq_s1[3] + sq_s1[4] + sq_s1[5];

			rho_s3    <= rho_s2;
			tot_s3    <= tot_s2;
			intl_s3   <= intl_s2;
			below_s3  <= below_s2;
			remain_s3 <= remain_s2;
			kin_s3    <= kin_s2;
			sumb_s3   <= sumb_s2;
			mprod_s3  <= 64'(taken_s2) * 64'(vol);
			// Quotient of the field energy would not fit in 32 bits.
			movf_s3   <= {1'b0, sumb_s2[63:32]} >= {rho_s2, 1'b0};

			res_s4.ctx.below    <= below_s3;
			res_s4.ctx.mass_low <= mass < min_mass;
			res_s4.ctx.mass     <= mass;
			res_s4.ctx.remain   <= remain_s3;
			res_s4.rho          <= rho_s3;
			res_s4.tot          <= tot_s3;
			res_s4.intl         <= intl_s3;
			res_s4.kin          <= kin_s3;
			res_s4.sumb         <= sumb_s3;
			res_s4.movf         <= movf_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = res_s4;

endmodule

// ===== rtl/core/sink_cell_screen_unit.sv =====
// Top level of the sink cell screen: configuration registers and the main pipeline.
//
// Each accepted item is one grid cell (density, energies, velocity and field).
// It yields exactly one result item: pass flag, reject reason, sink mass,
// remaining density and Jeans length, all Q16.16.
// Both channels use valid/ready; an item moves when valid and ready are high.
// The pipeline takes one cell per clock when not stalled. From acceptance to
// result_valid an item passes 4 front stages, a 32-stage divider for the
// magnetic energy, 3 stages for internal energy and the Jeans product, a
// 64-stage divider, a 32-stage square root and the output register. The two
// dividers and the square root are what set the latency. When result_ready
// is low with a result waiting, the whole pipeline holds and cell_ready drops;
// no item is lost or repeated. Reset clears all valid bits and loads the
// register defaults. Registers are written over the APB-style port at byte
// address 4*index. Write them only while idle; the block does not enforce this.
module sink_cell_screen_unit import scs_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               cell_valid,
	output logic               cell_ready,
	input  logic [31:0]        cell_density,
	input  logic signed [31:0] tot_energy,
	input  logic signed [31:0] int_energy,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic signed [31:0] mag_x,
	input  logic signed [31:0] mag_y,
	input  logic signed [31:0] mag_z,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               may_form,
	output logic [1:0]         reject_reason,
	output logic [31:0]        sink_amount,
	output logic [31:0]        remaining_density,
	output logic [31:0]        jeans_len
);

	localparam logic [31:0] SAT = sat_max(DATA_WIDTH);

	localparam logic [2:0] REG_THRESH = 3'd0;
	localparam logic [2:0] REG_FRAC   = 3'd1;
	localparam logic [2:0] REG_MINM   = 3'd2;
	localparam logic [2:0] REG_VOL    = 3'd3;
	localparam logic [2:0] REG_COEF   = 3'd4;
	localparam logic [2:0] REG_LIMIT  = 3'd5;
	localparam logic [2:0] REG_MODE   = 3'd6;

	localparam int MSB_W = $bits(mag_sb_t);
	localparam int JSB_W = $bits(jsb_t);

	localparam logic signed [49:0] E_MAG_OVF = 50'sd4294967296;

	logic [31:0] thr_q, minm_q, vol_q, coef_q, lim_q;
	logic [16:0] frac_q;
	logic [1:0]  mode_q;

	logic [2:0]  idx;
	logic        wr;
	logic        en;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= 32'd0;
			frac_q <= 17'd65536;
			minm_q <= 32'd0;
			vol_q  <= 32'd65536;
			coef_q <= 32'd65536;
			lim_q  <= 32'd262144;
			mode_q <= MODE_HYDRO;
		end else if (wr) begin
			unique case (idx)
				REG_THRESH: thr_q  <= pwdata;
				REG_FRAC:   frac_q <= pwdata[16:0];
				REG_MINM:   minm_q <= pwdata;
				REG_VOL:    vol_q  <= pwdata;
				REG_COEF:   coef_q <= pwdata;
				REG_LIMIT:  lim_q  <= pwdata;
				REG_MODE:   mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_THRESH: prdata = thr_q;
			REG_FRAC:   prdata = {15'd0, frac_q};
			REG_MINM:   prdata = minm_q;
			REG_VOL:    prdata = vol_q;
			REG_COEF:   prdata = coef_q;
			REG_LIMIT:  prdata = lim_q;
			REG_MODE:   prdata = {30'd0, mode_q};
			default:    prdata = 32'd0;
		endcase
	end

	// The whole pipeline advances unless a finished result is being held.
	assign en         = !result_valid || result_ready;
	assign cell_ready = en;

	logic   fr_v;
	front_t fr_d;

	scs_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (cell_valid),
		.cell_density (cell_density),
		.tot_energy   (tot_energy),
		.int_energy   (int_energy),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z),
		.mag_x        (mag_x),
		.mag_y        (mag_y),
		.mag_z        (mag_z),
		.thr          (thr_q),
		.frac         (frac_q),
		.min_mass     (minm_q),
		.vol          (vol_q),
		.out_valid    (fr_v),
		.out_data     (fr_d)
	);

	mag_sb_t          msb_in, msb_out;
	logic [MSB_W-1:0] msb_out_w;
	logic             md_v;
	logic [31:0]      md_q;

	always_comb begin
		msb_in.ctx  = fr_d.ctx;
		msb_in.rho  = fr_d.rho;
		msb_in.tot  = fr_d.tot;
		msb_in.intl = fr_d.intl;
		msb_in.kin  = fr_d.kin;
		msb_in.movf = fr_d.movf;
	end

	scs_div #(.QW(32), .DW(33), .SB_W(MSB_W)) u_mag_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_v),
		.num_hi    (fr_d.movf ? 33'd0 : {1'b0, fr_d.sumb[63:32]}),
		.num_lo    (fr_d.sumb[31:0]),
		.den       ({fr_d.rho, 1'b0}),
		.sb_in     (msb_in),
		.out_valid (md_v),
		.quot      (md_q),
		.sb_out    (msb_out_w)
	);

	assign msb_out = msb_out_w;

	// Internal energy. An overflowed field quotient already exceeds any positive
	// total energy, so it is replaced by two to the 32nd.
	logic signed [49:0] e_mag, e_val;

	always_comb begin
		e_mag = '0;
		if (mode_q == MODE_MHD) begin
			e_mag = msb_out.movf ? E_MAG_OVF : 50'(md_q);
		end
		if (mode_q == MODE_INT) begin
			e_val = 50'(msb_out.intl);
		end else begin
			e_val = 50'(msb_out.tot) - 50'(msb_out.kin) - e_mag;
		end
	end

	logic        v_s5, v_s6, v_s7, v_s8;
	ctx_t        ctx_s5, ctx_s6;
	logic [31:0] rho_s5, rho_s6, rho_s7;
	logic        eneg_s5, eneg_s6, ezero_s5, ezero_s6;
	logic [30:0] epos_s5;
	logic [62:0] jprod_s6;
	jsb_t        jsb_s7;
	logic [31:0] nhi_s7;
	logic [63:0] nlo_s7;
	logic [14:0] jhi;
	logic        jovf;

	assign jhi  = jprod_s6[62:48];
	assign jovf = {17'd0, jhi} >= rho_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= md_v;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5   <= msb_out.ctx;
			rho_s5   <= msb_out.rho;
			eneg_s5  <= e_val[49];
			ezero_s5 <= e_val == '0;
			epos_s5  <= e_val[30:0];

			ctx_s6   <= ctx_s5;
			rho_s6   <= rho_s5;
			eneg_s6  <= eneg_s5;
			ezero_s6 <= ezero_s5;
			jprod_s6 <= 63'(coef_q) * 63'(epos_s5);

			rho_s7        <= rho_s6;
			jsb_s7.ctx    <= ctx_s6;
			jsb_s7.e_neg  <= eneg_s6;
			jsb_s7.e_zero <= ezero_s6;
			jsb_s7.jovf   <= jovf;
			nhi_s7        <= jovf ? 32'd0 : {17'd0, jhi};
			nlo_s7        <= {jprod_s6[47:0], 16'd0};
		end
	end

	logic             jd_v;
	logic [63:0]      jd_q;
	logic [JSB_W-1:0] jd_sb;

	scs_div #(.QW(64), .DW(32), .SB_W(JSB_W)) u_jeans_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num_hi    (nhi_s7),
		.num_lo    (nlo_s7),
		.den       (rho_s7),
		.sb_in     (jsb_s7),
		.out_valid (jd_v),
		.quot      (jd_q),
		.sb_out    (jd_sb)
	);

	logic             sq_v;
	logic [31:0]      sq_root;
	logic [JSB_W-1:0] sq_sb_w;
	jsb_t             sq_sb;

	scs_sqrt #(.SB_W(JSB_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (jd_v),
		.radicand  (jd_q),
		.sb_in     (jd_sb),
		.out_valid (sq_v),
		.root      (sq_root),
		.sb_out    (sq_sb_w)
	);

	assign sq_sb = sq_sb_w;

	logic [31:0] jl_raw, jl;
	reason_t     rsn;

	always_comb begin
		jl_raw = sq_sb.jovf ? 32'hFFFF_FFFF : sq_root;
		if (sq_sb.ctx.below || sq_sb.ctx.mass_low || sq_sb.e_neg || sq_sb.e_zero) begin
			jl = 32'd0;
		end else begin
			jl = (jl_raw > SAT) ? SAT : jl_raw;
		end
		priority if (sq_sb.ctx.below) begin
			rsn = RSN_BELOW;
		end else if (sq_sb.ctx.mass_low) begin
			rsn = RSN_SMALL;
		end else if (sq_sb.e_neg) begin
			rsn = RSN_JEANS;
		end else if (jl < lim_q) begin
			rsn = RSN_PASS;
		end else begin
			rsn = RSN_JEANS;
		end
	end

	logic [1:0]  rsn_s8;
	logic        pass_s8;
	logic [31:0] mass_s8, remain_s8, jl_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsn_s8    <= rsn;
			pass_s8   <= rsn == RSN_PASS;
			mass_s8   <= sq_sb.ctx.mass;
			remain_s8 <= sq_sb.ctx.remain;
			jl_s8     <= jl;
		end
	end

	assign result_valid      = v_s8;
	assign may_form          = pass_s8;
	assign reject_reason     = rsn_s8;
	assign sink_amount       = mass_s8;
	assign remaining_density = remain_s8;
	assign jeans_len         = jl_s8;

endmodule

// ===== rtl/core/scs_chk.sv =====
// Port-level checker for the sink cell screen, bound to the top level.
`include "sink_cell_screen_unit_macros.svh"

module scs_chk import scs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cell_valid,
	input logic        cell_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic        may_form,
	input logic [1:0]  reject_reason,
	input logic [31:0] sink_amount,
	input logic [31:0] remaining_density,
	input logic [31:0] jeans_len
);

	// A held result keeps its value until it is taken.
	`SCS_ASSERT_NXT(a_hold, result_valid && !result_ready, result_valid && $stable(sink_amount) && $stable(remaining_density) && $stable(jeans_len))

	// A held result stops new cells from entering.
	`SCS_ASSERT_IMP(a_stall, result_valid && !result_ready, !cell_ready)

	`SCS_ASSERT_IMP(a_flag, result_valid, may_form == (reject_reason == RSN_PASS))

	// Cells below threshold take nothing and get no Jeans length.
	`SCS_ASSERT_IMP(a_below, result_valid && (reject_reason == RSN_BELOW), (sink_amount == 32'd0) && (jeans_len == 32'd0))

	`SCS_ASSERT_IMP(a_small, result_valid && (reject_reason == RSN_SMALL), jeans_len == 32'd0)

endmodule

bind sink_cell_screen_unit scs_chk u_scs_chk (.*);
